@@ rtl/core/key_sort_engine_assert.svh @@
// Assertion macros shared by the key sort engine RTL.
`ifndef KEY_SORT_ENGINE_ASSERT_SVH
`define KEY_SORT_ENGINE_ASSERT_SVH

// Checks that a condition holds at every clock edge outside reset.
`define KSE_ASSERT(label, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("key sort engine check failed");

// Checks that a condition implies a consequence in the same cycle.
`define KSE_ASSERT_IMPL(label, cond, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error("key sort engine check failed");

`endif

@@ rtl/core/kse_pkg.sv @@
// ----------------------------------------------------------------------------
// kse_pkg
// Shared constants and types of the key sort engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package kse_pkg;
   localparam int DEPTH_DEF     = 64;
   localparam int KEY_WIDTH_DEF = 32;
   localparam int CSR_ADDR_W    = 2;

   // Bits of the compare mode register.
   localparam int MODE_SIGNED_BIT = 0;
   localparam int MODE_DESC_BIT   = 1;
   localparam logic [CSR_ADDR_W-1:0] CSR_COMPARE_MODE = 2'd0;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FETCH,
      ST_HOLD,
      ST_SCAN,
      ST_PLACE,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;
endpackage
`default_nettype wire

@@ rtl/core/kse_if.sv @@
// ----------------------------------------------------------------------------
// kse_if
// Valid/ready channels for incoming keys and outgoing sorted keys.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface kse_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] key;
   logic        last_in;
   modport source (output valid, key, last_in, input ready);
   modport sink (input valid, key, last_in, output ready);
endinterface

interface kse_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] sorted_key;
   logic        last_out;
   modport source (output valid, sorted_key, last_out, input ready);
   modport sink (input valid, sorted_key, last_out, output ready);
endinterface
`default_nettype wire

@@ rtl/core/key_sort_engine.sv @@
// ----------------------------------------------------------------------------
// key_sort_engine
// Loads a set of keys into a memory, sorts them in place, streams them out.
// ----------------------------------------------------------------------------
// Keys enter on req_if, one item per cycle while the block is loading. Up to
// DEPTH keys are kept; later keys of the same set are dropped. The item with
// last_in set closes the set and starts the sort. The sorted keys then leave
// on rsp_if in the order chosen by the compare mode register, last_out set on
// the final one. The sort is an in-place insertion pass over the key memory:
// every compare needs one read of the single memory read port. Emission reads
// each key from the memory, then loads it into the output register. req_if.ready
// is low from the closing item until the last sorted key has been loaded into
// the output register. A stall on rsp_if holds the output register and pauses
// the memory reads. Reset empties the set, drops any pending result and sets
// the compare mode to unsigned ascending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "key_sort_engine_assert.svh"
module key_sort_engine #(
   parameter int DEPTH     = kse_pkg::DEPTH_DEF,
   parameter int KEY_WIDTH = kse_pkg::KEY_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   kse_req_if.sink                             req_if,
   kse_rsp_if.source                           rsp_if,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [kse_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                    pwdata,
   output logic      [31:0]                    prdata,
   output logic                                pready
);
   import kse_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [KEY_WIDTH-1:0] SIGN = KEY_WIDTH'(1) << (KEY_WIDTH - 1);

   logic [1:0]           mode;
   logic                 we;
   logic [AW-1:0]        waddr, raddr;
   logic [KEY_WIDTH-1:0] wdata, rdata;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [CW-1:0]        i_ff, i_in;
   logic [CW-1:0]        j_ff, j_in;
   logic [KEY_WIDTH-1:0] t_ff, t_in;
   logic                 out_valid_ff, out_valid_in;
   logic [31:0]          out_key_ff, out_key_in;
   logic                 out_last_ff, out_last_in;

   logic [KEY_WIDTH+31:0] key_ext, out_ext;
   logic [KEY_WIDTH-1:0]  cmp_x, cmp_y;
   logic                  shift_gt;
   logic [CW-1:0]         new_count;
   logic                  i_last;

   kse_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .mode    (mode)
   );

   kse_store #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH), .AW(AW)) u_store (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   assign key_ext = {{KEY_WIDTH{1'b0}}, req_if.key};
   assign out_ext = {32'd0, rdata};

   // Signed order is unsigned order with the sign bit flipped.
   assign cmp_x    = rdata ^ (mode[MODE_SIGNED_BIT] ? SIGN : '0);
   assign cmp_y    = t_ff ^ (mode[MODE_SIGNED_BIT] ? SIGN : '0);
   assign shift_gt = mode[MODE_DESC_BIT] ? (cmp_x < cmp_y) : (cmp_x > cmp_y);
   assign i_last   = (CW'(i_ff + 1'b1) == count_ff);
   assign new_count = (count_ff < CW'(DEPTH)) ? CW'(count_ff + 1'b1) : count_ff;

   assign req_if.ready      = (state_ff == ST_LOAD);
   assign rsp_if.valid      = out_valid_ff;
   assign rsp_if.sorted_key = out_key_ff;
   assign rsp_if.last_out   = out_last_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      t_in         = t_ff;
      we           = 1'b0;
      waddr        = j_ff[AW-1:0];
      wdata        = t_ff;
      raddr        = i_ff[AW-1:0];
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_key_in   = out_key_ff;
      out_last_in  = out_last_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_if.valid) begin
               if (count_ff < CW'(DEPTH)) begin
                  we    = 1'b1;
                  waddr = count_ff[AW-1:0];
                  wdata = key_ext[KEY_WIDTH-1:0];
               end
               count_in = new_count;
               if (req_if.last_in) begin
                  if (new_count == CW'(1)) begin
                     i_in     = '0;
                     state_in = ST_EMIT_RD;
                  end else begin
                     i_in     = CW'(1);
                     state_in = ST_FETCH;
                  end
               end
            end
         end
         ST_FETCH: begin
            raddr    = i_ff[AW-1:0];
            state_in = ST_HOLD;
         end
         ST_HOLD: begin
            t_in     = rdata;
            j_in     = i_ff;
            raddr    = AW'(i_ff - 1'b1);
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            we    = 1'b1;
            waddr = j_ff[AW-1:0];
            if (shift_gt) begin
               // Move the key that must come after the held key up one place and look one further down.
               wdata = rdata;
               j_in  = CW'(j_ff - 1'b1);
               raddr = AW'(j_ff - 2'd2);
               if (j_ff == CW'(1)) begin
                  state_in = ST_PLACE;
               end
            end else begin
               wdata = t_ff;
               if (i_last) begin
                  i_in     = '0;
                  state_in = ST_EMIT_RD;
               end else begin
                  i_in     = CW'(i_ff + 1'b1);
                  state_in = ST_FETCH;
               end
            end
         end
         ST_PLACE: begin
            we    = 1'b1;
            waddr = '0;
            wdata = t_ff;
            if (i_last) begin
               i_in     = '0;
               state_in = ST_EMIT_RD;
            end else begin
               i_in     = CW'(i_ff + 1'b1);
               state_in = ST_FETCH;
            end
         end
         ST_EMIT_RD: begin
            raddr = i_ff[AW-1:0];
            if (!out_valid_ff || rsp_if.ready) begin
               state_in = ST_EMIT_OUT;
            end
         end
         ST_EMIT_OUT: begin
            out_valid_in = 1'b1;
            out_key_in   = out_ext[31:0];
            out_last_in  = i_last;
            if (i_last) begin
               count_in = '0;
               i_in     = '0;
               state_in = ST_LOAD;
            end else begin
               i_in     = CW'(i_ff + 1'b1);
               state_in = ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff        <= t_in;
      out_key_ff  <= out_key_in;
      out_last_ff <= out_last_in;
   end

   `KSE_ASSERT(a_count_bound, count_ff <= CW'(DEPTH))
   `KSE_ASSERT_IMPL(a_scan_index, state_ff == ST_SCAN, (j_ff != '0) && (j_ff <= i_ff))
   `KSE_ASSERT_IMPL(a_emit_empty, state_ff == ST_EMIT_OUT, !out_valid_ff)
   `KSE_ASSERT_IMPL(a_sort_index, state_ff == ST_FETCH, (i_ff != '0) && (i_ff < count_ff))
endmodule
`default_nettype wire

@@ rtl/core/kse_store.sv @@
// ----------------------------------------------------------------------------
// kse_store
// Key memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module kse_store #(
   parameter int DEPTH     = 64,
   parameter int KEY_WIDTH = 32,
   parameter int AW        = $clog2(DEPTH)
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [AW-1:0]        waddr,
   input  wire logic [KEY_WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]        raddr,
   output logic      [KEY_WIDTH-1:0] rdata
);
   logic [KEY_WIDTH-1:0] mem [DEPTH];
   logic [KEY_WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

@@ rtl/core/kse_csr.sv @@
// ----------------------------------------------------------------------------
// kse_csr
// APB-style register port holding the compare mode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module kse_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [kse_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]                    pwdata,
   output logic      [31:0]                    prdata,
   output logic                                pready,
   output logic      [1:0]                     mode
);
   import kse_pkg::*;

   logic [1:0] mode_ff;
   logic [1:0] mode_in;

   always_comb begin
      mode_in = mode_ff;
      if (psel && penable && pwrite && (paddr == CSR_COMPARE_MODE)) begin
         mode_in = pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 2'd0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_COMPARE_MODE) ? {30'd0, mode_ff} : 32'd0;
   assign mode   = mode_ff;
endmodule
`default_nettype wire

@@ verif/key_sort_engine_test.sv @@
// ----------------------------------------------------------------------------
// key_sort_engine_test
// Loads key sets, predicts their sorted order per compare mode and checks the
// emitted keys item by item, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module key_sort_engine_test;
   import kse_pkg::*;

   localparam int SET_MAX     = 64;
   localparam int WATCH_LIMIT = 200000;

   typedef struct packed {
      logic [31:0] key;
      logic        last;
   } key_item_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   kse_req_if req_if ();
   kse_rsp_if rsp_if ();

   key_sort_engine DUT (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   key_item_t pending_keys[$];
   key_item_t sorted_expect[$];
   logic [31:0] loaded_set[$];
   logic [1:0] sort_mode = 2'd0;
   int mismatches = 0;
   int idle_cycles = 0;
   bit quiet_run = 1'b0;
   bit timed_out = 1'b0;

   initial begin
      forever #10 clock = ~clock;
   end

   // True when key x must come after key y in the current mode.
   function automatic bit comes_after(logic [31:0] x, logic [31:0] y);
      logic [31:0] a;
      logic [31:0] b;
      a = x;
      b = y;
      if (sort_mode[MODE_SIGNED_BIT]) begin
         a[31] = ~a[31];
         b[31] = ~b[31];
      end
      return sort_mode[MODE_DESC_BIT] ? (a < b) : (a > b);
   endfunction

   // Equal keys are identical bits, so any stable sort gives the same order.
   task automatic predict_sorted_set();
      logic [31:0] keys[$];
      logic [31:0] t;
      int j;
      keys = loaded_set;
      for (int i = 1; i < keys.size(); i++) begin
         t = keys[i];
         j = i;
         while (j > 0 && comes_after(keys[j-1], t)) begin
            keys[j] = keys[j-1];
            j--;
         end
         keys[j] = t;
      end
      foreach (keys[i]) sorted_expect.push_back({keys[i], i == keys.size() - 1});
      loaded_set.delete();
   endtask

   // Driver: keys go out with random gaps, except in the quiet stretch.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.key <= '0;
         req_if.last_in <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            if (loaded_set.size() < SET_MAX) loaded_set.push_back(req_if.key);
            if (req_if.last_in) predict_sorted_set();
         end
         if ((!req_if.valid || req_if.ready) ) begin
            if (pending_keys.size() > 0 && (quiet_run || $urandom_range(99) >= 31)) begin
               key_item_t it;
               it = pending_keys.pop_front();
               req_if.valid <= 1'b1;
               req_if.key <= it.key;
               req_if.last_in <= it.last;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each sorted key and stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= quiet_run || $urandom_range(99) >= 31;
         if (rsp_if.valid && rsp_if.ready) begin
            if (sorted_expect.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected sorted key %h last %b", rsp_if.sorted_key,
                     rsp_if.last_out);
            end else begin
               key_item_t e;
               e = sorted_expect.pop_front();
               if (e.key !== rsp_if.sorted_key || e.last !== rsp_if.last_out) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("sorted key mismatch: expected %h last %b, got %h last %b",
                        e.key, e.last, rsp_if.sorted_key, rsp_if.last_out);
               end
            end
         end
      end
   end

   // Watchdog on cycles in which no item moves.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("key_sort_engine verification failed");
         $finish;
      end
   end

   task automatic write_mode(logic [1:0] m);
      @(posedge clock);
      psel <= 1'b1;
      pwrite <= 1'b1;
      paddr <= CSR_COMPARE_MODE;
      pwdata <= {30'd0, m};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      sort_mode = m;
   endtask

   task automatic add_set(int n, int style);
      logic [31:0] k;
      for (int i = 0; i < n; i++) begin
         case (style)
            0: k = $urandom();
            1: k = i * 3;
            2: k = (n - i) * 5;
            3: k = $urandom_range(3) << 30;
            default: k = {$urandom_range(1) ? 32'hFFFF_FFF0 : 32'h0} | $urandom_range(15);
         endcase
         pending_keys.push_back({k, i == n - 1});
      end
   endtask

   task automatic drain();
      wait (pending_keys.size() == 0 && !req_if.valid && sorted_expect.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      int n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      // Directed sets: extremes, one key, sorted, reversed.
      pending_keys.push_back({32'h0000_0000, 1'b0});
      pending_keys.push_back({32'hFFFF_FFFF, 1'b0});
      pending_keys.push_back({32'h8000_0000, 1'b0});
      pending_keys.push_back({32'h7FFF_FFFF, 1'b1});
      pending_keys.push_back({32'h1234_5678, 1'b1});
      add_set(8, 1);
      add_set(8, 2);
      drain();
      for (int m = 3; m >= 0; m--) begin
         write_mode(m[1:0]);
         add_set(5, 4);
         add_set(45, 0);
         drain();
      end
      // Store overflow: keys past the depth are dropped.
      add_set(70, 0);
      drain();
      for (int p = 0; p < 4; p++) begin
         write_mode(2'($urandom_range(3)));
         quiet_run = (p == 2);
         for (int s = 0; s < 4; s++) begin
            n = ($urandom_range(9) == 0) ? $urandom_range(41, 64) : $urandom_range(1, 20);
            add_set(n, $urandom_range(4));
         end
         drain();
      end
      if (mismatches == 0)
         $display("key_sort_engine verification clean");
      else
         $display("key_sort_engine verification failed");
      $finish;
   end
endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/kse_pkg.sv
rtl/core/kse_if.sv
rtl/core/kse_store.sv
rtl/core/kse_csr.sv
rtl/core/key_sort_engine.sv
verif/key_sort_engine_test.sv
